// ===== hdl/hvt_pkg.sv =====
package hvt_pkg;

   // Parameter defaults for the core
   localparam int COEF_WIDTH_DEFAULT    = 16;
   localparam int COORD_WIDTH_DEFAULT   = 24;
   localparam int FRACTION_BITS_DEFAULT = 12;

   // Fixed field widths of the words on the ports
   localparam int COORD_FIELD_WIDTH = 24;
   localparam int RESULT_WIDTH      = 32;
   localparam int ROW_REG_WIDTH     = 64;
   localparam int SLOT_WIDTH        = 16;
   localparam int ROW_COUNT         = 4;
   localparam int COORD_COUNT       = 3;
   localparam int CSR_INDEX_WIDTH   = 8;

   // Register indexes on the CSR port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW0 = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW1 = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW2 = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW3 = 8'd3;

   // Input word: one vertex
   typedef struct packed {
      logic signed [COORD_FIELD_WIDTH-1:0] x_in;
      logic signed [COORD_FIELD_WIDTH-1:0] y_in;
      logic signed [COORD_FIELD_WIDTH-1:0] z_in;
   } req_type;

   // Result word: one transformed homogeneous point
   typedef struct packed {
      logic signed [RESULT_WIDTH-1:0] x_out;
      logic signed [RESULT_WIDTH-1:0] y_out;
      logic signed [RESULT_WIDTH-1:0] z_out;
      logic signed [RESULT_WIDTH-1:0] w_out;
   } rsp_type;

endpackage

// ===== hdl/homogeneous_vertex_transform_core.sv =====
// Channel  | Ports                                  | Handshake
// ---------+----------------------------------------+--------------------------------
// request  | start, busy, req_data                  | taken when start & !busy
// response | rsp_valid, rsp_data                    | one-cycle strobe, no backpressure
// csr      | csr_valid, csr_ready, csr_index/_data  | written when csr_valid & csr_ready
//
// One vertex is taken every clock; busy stays low.
// The pipeline stages are multiply, row sum with rounding, shift and saturate.
// The 12 coefficient-by-coordinate multipliers set the rate, one product each per cycle.
// Synchronous reset clears the valid bits and loads the identity matrix.
// The receiver cannot stall, so the pipeline never stops.
module homogeneous_vertex_transform_core #(
   parameter int COEF_WIDTH    = hvt_pkg::COEF_WIDTH_DEFAULT,
   parameter int COORD_WIDTH   = hvt_pkg::COORD_WIDTH_DEFAULT,
   parameter int FRACTION_BITS = hvt_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  hvt_pkg::req_type                          req_data,
   output logic                                      rsp_valid,
   output hvt_pkg::rsp_type                          rsp_data,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [hvt_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [hvt_pkg::ROW_REG_WIDTH-1:0]         csr_data
);

   localparam int PROD_WIDTH  = COEF_WIDTH + COORD_WIDTH;
   localparam int TRANS_WIDTH = COEF_WIDTH + FRACTION_BITS;
   localparam int SUM_WIDTH   = ((PROD_WIDTH > TRANS_WIDTH) ? PROD_WIDTH : TRANS_WIDTH) + 3;
   localparam int SHIFT_WIDTH = SUM_WIDTH - FRACTION_BITS;
   localparam int RW          = hvt_pkg::RESULT_WIDTH;
   localparam int ROWS        = hvt_pkg::ROW_COUNT;
   localparam int COLS        = hvt_pkg::COORD_COUNT;
   localparam int SLOT        = hvt_pkg::SLOT_WIDTH;

   // Matrix rows
   logic [hvt_pkg::ROW_REG_WIDTH-1:0] row_ff [ROWS];
   logic [hvt_pkg::ROW_REG_WIDTH-1:0] row_in [ROWS];

   // Pipeline registers
   logic                           v1_ff, v2_ff, v3_ff;
   logic                           v1_in, v2_in, v3_in;
   logic signed [PROD_WIDTH-1:0]   prod_ff [ROWS][COLS];
   logic signed [PROD_WIDTH-1:0]   prod_in [ROWS][COLS];
   logic signed [COEF_WIDTH-1:0]   trans_ff [ROWS];
   logic signed [COEF_WIDTH-1:0]   trans_in [ROWS];
   logic signed [SUM_WIDTH-1:0]    sum_ff [ROWS];
   logic signed [SUM_WIDTH-1:0]    sum_in [ROWS];
   logic signed [RW-1:0]           res_in [ROWS];
   hvt_pkg::rsp_type               rsp_ff;
   hvt_pkg::rsp_type               rsp_in;

   logic signed [COORD_WIDTH-1:0]  coord [COLS];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Load a row register on a CSR write; drop writes to unknown indexes
   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         row_in[r] = row_ff[r];
      end
      if (csr_valid && csr_ready) begin
         case (csr_index)
            hvt_pkg::CSR_ROW0: row_in[0] = csr_data;
            hvt_pkg::CSR_ROW1: row_in[1] = csr_data;
            hvt_pkg::CSR_ROW2: row_in[2] = csr_data;
            hvt_pkg::CSR_ROW3: row_in[3] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < ROWS; r++) begin
         if (reset) begin
            row_ff[r] <= hvt_pkg::ROW_REG_WIDTH'(1) << (FRACTION_BITS + SLOT * r);
         end else begin
            row_ff[r] <= row_in[r];
         end
      end
   end

   // Stage 1: take the low coordinate bits and form all products
   always_comb begin
      coord[0] = $signed(COORD_WIDTH'(unsigned'(req_data.x_in)));
      coord[1] = $signed(COORD_WIDTH'(unsigned'(req_data.y_in)));
      coord[2] = $signed(COORD_WIDTH'(unsigned'(req_data.z_in)));
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLS; c++) begin
            prod_in[r][c] = $signed(row_ff[r][SLOT*c +: COEF_WIDTH]) * coord[c];
         end
         trans_in[r] = $signed(row_ff[r][SLOT*COLS +: COEF_WIDTH]);
      end
      v1_in = start && !busy;
   end

   // Stage 2: sum each row with the translation and the rounding bias
   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         sum_in[r] = SUM_WIDTH'(prod_ff[r][0]) + SUM_WIDTH'(prod_ff[r][1])
                   + SUM_WIDTH'(prod_ff[r][2])
                   + (SUM_WIDTH'(trans_ff[r]) <<< FRACTION_BITS)
                   + (SUM_WIDTH'(1) << (FRACTION_BITS - 1));
      end
      v2_in = v1_ff;
   end

   // Stage 3: floor by the fraction bits, then clamp to the result range
   for (genvar r = 0; r < ROWS; r++) begin : g_sat
      logic signed [SHIFT_WIDTH-1:0] shifted;
      assign shifted = sum_ff[r][SUM_WIDTH-1:FRACTION_BITS];
      if (SHIFT_WIDTH > RW) begin : g_clamp
         logic [SHIFT_WIDTH-RW:0] upper;
         assign upper = shifted[SHIFT_WIDTH-1:RW-1];
         always_comb begin
            if ((&upper) || !(|upper)) begin
               res_in[r] = shifted[RW-1:0];
            end else if (shifted[SHIFT_WIDTH-1]) begin
               res_in[r] = {1'b1, {(RW-1){1'b0}}};
            end else begin
               res_in[r] = {1'b0, {(RW-1){1'b1}}};
            end
         end
      end else begin : g_extend
         assign res_in[r] = RW'(shifted);
      end
   end

   always_comb begin
      rsp_in.x_out = res_in[0];
      rsp_in.y_out = res_in[1];
      rsp_in.z_out = res_in[2];
      rsp_in.w_out = res_in[3];
      v3_in        = v2_ff;
   end

   // Advance valid bits; payload needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      trans_ff <= trans_in;
      sum_ff   <= sum_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = v3_ff;
   assign rsp_data  = rsp_ff;

   // Every accepted word reaches the output as a result word
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("accepted word did not reach the output in three cycles");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("result word without a matching request");

   a_csr_row0: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index == hvt_pkg::CSR_ROW0)
         |=> row_ff[0] == $past(csr_data))
      else $error("row 0 write not taken");

   a_csr_stray: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index != hvt_pkg::CSR_ROW0
         && csr_index != hvt_pkg::CSR_ROW1 && csr_index != hvt_pkg::CSR_ROW2
         && csr_index != hvt_pkg::CSR_ROW3)
         |=> $stable(row_ff[3]) && $stable(row_ff[0]))
      else $error("write to unknown index changed a row");

endmodule

// ===== sim/hvt_transform_checker.sv =====
`timescale 1ns / 100ps

// Predict each transformed vertex from the accepted input words and the
// matrix rows written on the CSR port, and compare every result word.
module hvt_transform_checker
   import hvt_pkg::*;
#(
   parameter int COEF_WIDTH    = COEF_WIDTH_DEFAULT,
   parameter int COORD_WIDTH   = COORD_WIDTH_DEFAULT,
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  req_type                    req_data,
   input  logic                       rsp_valid,
   input  rsp_type                    rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ROW_REG_WIDTH-1:0]   csr_data,
   output int                         mismatch_count,
   output int                         points_in_flight
);

   localparam longint RESULT_MAX   = 64'sd2147483647;
   localparam longint RESULT_MIN   = -64'sd2147483648;
   localparam int     REPORT_LIMIT = 100;

   logic [ROW_REG_WIDTH-1:0] row_coefs [ROW_COUNT];
   rsp_type                  expected_points [$];
   rsp_type                  oldest_point;

   initial begin
      mismatch_count   = 0;
      points_in_flight = 0;
   end

   // Read the low width bits of raw as a two's complement value
   function automatic longint to_signed(input logic [63:0] raw, input int width);
      longint mask;
      longint value;
      mask  = (64'sd1 <<< width) - 1;
      value = longint'(raw) & mask;
      if (value[width-1])
         value = value - (64'sd1 <<< width);
      return value;
   endfunction

   function automatic longint coefficient(input int row, input int col);
      return to_signed(64'(row_coefs[row][SLOT_WIDTH*col +: SLOT_WIDTH]), COEF_WIDTH);
   endfunction

   // Multiply (x, y, z, 1) by the matrix, round half up and saturate each row
   function automatic rsp_type transform_vertex(input req_type vertex);
      longint      coord [COORD_COUNT];
      longint      acc;
      longint      rounded;
      logic [31:0] row_out [ROW_COUNT];
      rsp_type     point;
      coord[0] = to_signed(64'(unsigned'(vertex.x_in)), COORD_WIDTH);
      coord[1] = to_signed(64'(unsigned'(vertex.y_in)), COORD_WIDTH);
      coord[2] = to_signed(64'(unsigned'(vertex.z_in)), COORD_WIDTH);
      for (int r = 0; r < ROW_COUNT; r++) begin
         acc = coefficient(r, 3) * (64'sd1 <<< FRACTION_BITS);
         for (int c = 0; c < COORD_COUNT; c++)
            acc = acc + coefficient(r, c) * coord[c];
         rounded = (acc + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
         if (rounded > RESULT_MAX)
            rounded = RESULT_MAX;
         if (rounded < RESULT_MIN)
            rounded = RESULT_MIN;
         row_out[r] = rounded[31:0];
      end
      point.x_out = row_out[0];
      point.y_out = row_out[1];
      point.z_out = row_out[2];
      point.w_out = row_out[3];
      return point;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < REPORT_LIMIT)
         $display("%0t ERROR: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_coordinate(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %08h expected %08h", field, got, want));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         // Drop anything in flight and reload the identity matrix
         expected_points.delete();
         for (int r = 0; r < ROW_COUNT; r++)
            row_coefs[r] = 64'(64'd1 << FRACTION_BITS) << (SLOT_WIDTH * r);
      end else begin
         // Compare a result word with the oldest prediction
         if (rsp_valid) begin
            if (expected_points.size() == 0) begin
               report_mismatch($sformatf("result word %h with none expected", rsp_data));
            end else begin
               oldest_point = expected_points.pop_front();
               check_coordinate("x_out", rsp_data.x_out, oldest_point.x_out);
               check_coordinate("y_out", rsp_data.y_out, oldest_point.y_out);
               check_coordinate("z_out", rsp_data.z_out, oldest_point.z_out);
               check_coordinate("w_out", rsp_data.w_out, oldest_point.w_out);
            end
         end
         // Predict the result of an accepted vertex
         if (start && !busy)
            expected_points.push_back(transform_vertex(req_data));
         // Track matrix writes; other indexes are ignored
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROW0: row_coefs[0] = csr_data;
               CSR_ROW1: row_coefs[1] = csr_data;
               CSR_ROW2: row_coefs[2] = csr_data;
               CSR_ROW3: row_coefs[3] = csr_data;
               default: ;
            endcase
         end
      end
      points_in_flight <= expected_points.size();
   end

endmodule

// ===== sim/homogeneous_vertex_transform_core_tb.sv =====
`timescale 1ns / 100ps

module homogeneous_vertex_transform_core_tb;
   import hvt_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int RANDOM_PHASES   = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_LOW  = 8'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_HIGH = 8'hFF;

   localparam logic [SLOT_WIDTH-1:0] COEF_MAX  = 16'h7FFF;
   localparam logic [SLOT_WIDTH-1:0] COEF_MIN  = 16'h8000;
   localparam logic [SLOT_WIDTH-1:0] COEF_ONE  = 16'h1000;
   localparam logic [SLOT_WIDTH-1:0] COEF_HALF = 16'h0800;
   localparam logic [SLOT_WIDTH-1:0] COEF_ZERO = 16'h0000;

   localparam logic [COORD_FIELD_WIDTH-1:0] COORD_MAX  = 24'h7FFFFF;
   localparam logic [COORD_FIELD_WIDTH-1:0] COORD_MIN  = 24'h800000;
   localparam logic [COORD_FIELD_WIDTH-1:0] COORD_ZERO = 24'h000000;
   localparam logic [COORD_FIELD_WIDTH-1:0] COORD_ONE  = 24'h000001;
   localparam logic [COORD_FIELD_WIDTH-1:0] COORD_NEG  = 24'hFFFFFF;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       start     = 1'b0;
   logic                       busy;
   req_type                    req_data  = '0;
   logic                       rsp_valid;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [ROW_REG_WIDTH-1:0]   csr_data  = '0;

   int mismatch_count;
   int points_in_flight;
   int burst_left  = 0;
   int idle_cycles = 0;

   always #1 clock = ~clock;

   homogeneous_vertex_transform_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   hvt_transform_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .points_in_flight (points_in_flight)
   );

   // Abort when no word moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_vertex(input logic [COORD_FIELD_WIDTH-1:0] x,
                                           input logic [COORD_FIELD_WIDTH-1:0] y,
                                           input logic [COORD_FIELD_WIDTH-1:0] z);
      req_type vertex;
      vertex.x_in = x;
      vertex.y_in = y;
      vertex.z_in = z;
      return vertex;
   endfunction

   // Mix full-range, mid-range, extreme and near-zero coordinates
   function automatic logic [COORD_FIELD_WIDTH-1:0] random_coordinate();
      case ($urandom_range(0, 4))
         0, 1: return COORD_FIELD_WIDTH'($urandom);
         2: return COORD_FIELD_WIDTH'($urandom_range(0, 32'hFFFF)) - 24'h8000;
         3: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         default: return COORD_FIELD_WIDTH'($urandom_range(0, 7)) - 24'd4;
      endcase
   endfunction

   function automatic req_type random_vertex();
      return make_vertex(random_coordinate(), random_coordinate(), random_coordinate());
   endfunction

   // Full random row, small coefficients, or a mix of extreme, zero, one and half coefficients
   function automatic logic [ROW_REG_WIDTH-1:0] random_row(input int mode);
      logic [ROW_REG_WIDTH-1:0] row;
      row = {$urandom, $urandom};
      if (mode != 0) begin
         for (int c = 0; c < ROW_COUNT; c++) begin
            if (mode == 1) begin
               row[SLOT_WIDTH*c +: SLOT_WIDTH] = SLOT_WIDTH'($urandom_range(0, 16'h3FFF)) - 16'h2000;
            end else begin
               case ($urandom_range(0, 4))
                  0: row[SLOT_WIDTH*c +: SLOT_WIDTH] = COEF_MAX;
                  1: row[SLOT_WIDTH*c +: SLOT_WIDTH] = COEF_MIN;
                  2: row[SLOT_WIDTH*c +: SLOT_WIDTH] = COEF_ZERO;
                  3: row[SLOT_WIDTH*c +: SLOT_WIDTH] = COEF_ONE;
                  default: row[SLOT_WIDTH*c +: SLOT_WIDTH] = COEF_HALF;
               endcase
            end
         end
      end
      return row;
   endfunction

   // Present a vertex and hold it until taken; idle between bursts
   task automatic send_vertex(input req_type vertex);
      start    <= 1'b1;
      req_data <= vertex;
      do @(posedge clock); while (busy);
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
   endtask

   // Stop sending and wait for every predicted result word
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (points_in_flight != 0);
   endtask

   // Hold the CSR valid high across a sequence of writes
   task automatic write_row(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [ROW_REG_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_matrix(input logic [ROW_REG_WIDTH-1:0] row0,
                              input logic [ROW_REG_WIDTH-1:0] row1,
                              input logic [ROW_REG_WIDTH-1:0] row2,
                              input logic [ROW_REG_WIDTH-1:0] row3,
                              input bit stray_write);
      write_row(CSR_ROW0, row0);
      write_row(CSR_ROW1, row1);
      write_row(CSR_ROW2, row2);
      write_row(CSR_ROW3, row3);
      // Writes past the last row must leave the matrix alone
      if (stray_write)
         write_row($urandom_range(0, 1) ? CSR_UNUSED_LOW : CSR_UNUSED_HIGH, {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   initial begin
      int mode;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      drain_results();

      // Identity matrix straight out of reset
      send_vertex(make_vertex(COORD_ZERO, COORD_ZERO, COORD_ZERO));
      send_vertex(make_vertex(COORD_MAX, COORD_MAX, COORD_MAX));
      send_vertex(make_vertex(COORD_MIN, COORD_MIN, COORD_MIN));
      send_vertex(make_vertex(COORD_NEG, COORD_ONE, COORD_NEG));
      send_vertex(make_vertex(24'h555555, 24'hAAAAAA, 24'h0F0F0F));
      send_vertex(make_vertex(24'hF0F0F0, 24'h000003, 24'hFFFFFD));
      drain_results();

      // Extreme coefficients, half-LSB ties in row 2, pure translation in row 3
      load_matrix({4{COEF_MAX}}, {4{COEF_MIN}},
                  {COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_HALF},
                  {COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO}, 1'b1);
      send_vertex(make_vertex(COORD_MAX, COORD_MAX, COORD_MAX));
      send_vertex(make_vertex(COORD_MIN, COORD_MIN, COORD_MIN));
      send_vertex(make_vertex(COORD_MAX, COORD_MIN, COORD_MAX));
      send_vertex(make_vertex(COORD_ONE, COORD_ZERO, COORD_ZERO));
      send_vertex(make_vertex(COORD_NEG, COORD_ZERO, COORD_ZERO));
      send_vertex(make_vertex(24'h000003, COORD_ZERO, COORD_ZERO));
      send_vertex(make_vertex(24'hFFFFFD, COORD_ZERO, COORD_ZERO));
      send_vertex(make_vertex(COORD_ZERO, COORD_ZERO, COORD_ZERO));
      drain_results();

      // Random matrices, each followed by a stream of random vertices
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         mode = phase % 3;
         load_matrix(random_row(mode), random_row(mode), random_row(mode), random_row(mode),
                     phase[0]);
         repeat (ITEMS_PER_PHASE) send_vertex(random_vertex());
         drain_results();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== homogeneous_vertex_transform_core.f =====
hdl/hvt_pkg.sv
hdl/homogeneous_vertex_transform_core.sv
sim/hvt_transform_checker.sv
sim/homogeneous_vertex_transform_core_tb.sv
